// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i with reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SIAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SIAL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/sial_pkg.sv =====
// ----------------------------------------------------------------------------
// sial_pkg
// Request/response types and codes for the shift-insert array list.
// ----------------------------------------------------------------------------
package sial_pkg;

  // list geometry
  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;

  // request kinds
  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_PREPEND = 3'd1;
  localparam logic [2:0] KIND_INSERT  = 3'd2;
  localparam logic [2:0] KIND_POP     = 3'd3;
  localparam logic [2:0] KIND_DELETE  = 3'd4;
  localparam logic [2:0] KIND_READ    = 3'd5;

  // response status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0]                     kind;
    logic [$clog2(CAPACITY)-1:0]    position;
    logic signed [WORD_BITS-1:0]    item_value;
  } sial_req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0]    read_value;
    logic [$clog2(CAPACITY+1)-1:0]  fill_count;
    logic                           empty_flag;
    logic [1:0]                     status;
  } sial_rsp_t;

endpackage

// ===== design/sial_ram.sv =====
// ----------------------------------------------------------------------------
// sial_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sial_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/shift_insert_array_list_core.sv =====
// ----------------------------------------------------------------------------
// shift_insert_array_list_core
// Fixed-capacity ordered list of signed words held in one RAM, with append,
// prepend, insert, pop, delete and read requests.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Ports                 Transfer
// request   in   start_i, req_i        start_i high while busy_o low
// response  out  valid_o, rsp_o        valid_o high for one cycle
//
// Every request gives exactly one response. Errors, ignored kinds and a
// delete of the last element answer from idle; all else holds busy_o high
// until its response strobe. Append and a prepend to an empty list write
// the value in S_FILL; pop and read pass RAM data out in S_RDOUT; other
// prepends and inserts inside the list shift entries up in S_SHUP, then
// write the value; an insert at or past the count zero-fills the gap in
// S_FILL, then writes the value; a delete inside the list shifts entries
// down in S_SHDN. Shifts and gap fills move one element per cycle, paced
// by the single RAM write port, with the read pipelined one ahead. Reset
// clears state, count and strobe; the RAM needs no clearing as only
// entries below the count are ever read. The receiver cannot stall; a new
// request may be taken in the same cycle as the previous response strobe.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shift_insert_array_list_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  sial_pkg::sial_req_t   req_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output sial_pkg::sial_rsp_t   rsp_o
);
  import sial_pkg::*;

  localparam int AW = $clog2(CAPACITY);      // RAM address
  localparam int CW = $clog2(CAPACITY + 1);  // count, holds CAPACITY itself
  localparam int XW = CW + 4;                // room to compare index and count

  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;  // zero gap, then new value
  localparam logic [2:0] S_SHUP  = 3'd2;  // shift up, then new value
  localparam logic [2:0] S_SHDN  = 3'd3;  // shift down after delete
  localparam logic [2:0] S_RDOUT = 3'd4;  // RAM data to response

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        cur_q, cur_d;    // index being written
  logic [AW-1:0]        pos_q, pos_d;    // where the new value lands
  logic [WORD_BITS-1:0] val_q, val_d;
  logic                 valid_q, valid_d;
  sial_rsp_t            rsp_q, rsp_d;

  // RAM port
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  logic [XW-1:0] pos_x, cnt_x, cap_x;
  logic          full;

  assign pos_x = XW'(req_i.position);
  assign cnt_x = XW'(count_q);
  assign cap_x = XW'(CapC);
  assign full  = (count_q >= CapC);

  sial_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    cur_d   = cur_q;
    pos_d   = pos_q;
    val_d   = val_q;
    valid_d = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = cur_q;
    wdata   = val_q;
    raddr   = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          // default: immediate response, nothing changes
          valid_d          = 1'b1;
          rsp_d.read_value = '0;
          rsp_d.status     = ST_OK;
          val_d            = req_i.item_value;
          case (req_i.kind)
            KIND_APPEND: begin
              if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                valid_d = 1'b0;
                cur_d   = AW'(count_q);
                pos_d   = AW'(count_q);
                state_d = S_FILL;
              end
            end
            KIND_PREPEND: begin
              if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                valid_d = 1'b0;
                cur_d   = AW'(count_q);
                pos_d   = '0;
                raddr   = AW'(count_q - CW'(1));
                state_d = (count_q == '0) ? S_FILL : S_SHUP;
              end
            end
            KIND_INSERT: begin
              if (pos_x >= cap_x) begin
                rsp_d.status = ST_INDEX;
              end else if (pos_x >= cnt_x) begin
                valid_d = 1'b0;
                cur_d   = AW'(count_q);
                pos_d   = req_i.position;
                state_d = S_FILL;
              end else if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                valid_d = 1'b0;
                cur_d   = AW'(count_q);
                pos_d   = req_i.position;
                raddr   = AW'(count_q - CW'(1));
                state_d = S_SHUP;
              end
            end
            KIND_POP: begin
              if (count_q == '0) begin
                rsp_d.status = ST_EMPTY;
              end else begin
                valid_d = 1'b0;
                count_d = count_q - CW'(1);
                raddr   = AW'(count_q - CW'(1));
                state_d = S_RDOUT;
              end
            end
            KIND_DELETE: begin
              if (pos_x >= cnt_x) begin
                rsp_d.status = ST_INDEX;
              end else begin
                count_d = count_q - CW'(1);
                if (pos_x + XW'(1) != cnt_x) begin
                  valid_d = 1'b0;
                  cur_d   = req_i.position;
                  raddr   = req_i.position + AW'(1);
                  state_d = S_SHDN;
                end
              end
            end
            KIND_READ: begin
              if (pos_x >= cnt_x) begin
                rsp_d.status = ST_INDEX;
              end else begin
                valid_d = 1'b0;
                raddr   = req_i.position;
                state_d = S_RDOUT;
              end
            end
            default: ;  // unused kinds: plain ok response
          endcase
        end
      end

      S_FILL: begin
        we    = 1'b1;
        wdata = (cur_q == pos_q) ? val_q : '0;
        if (cur_q == pos_q) begin
          count_d          = CW'(pos_q) + CW'(1);
          valid_d          = 1'b1;
          rsp_d.read_value = '0;
          rsp_d.status     = ST_OK;
          state_d          = S_IDLE;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end

      S_SHUP: begin
        we = 1'b1;
        if (cur_q == pos_q) begin
          wdata            = val_q;
          count_d          = count_q + CW'(1);
          valid_d          = 1'b1;
          rsp_d.read_value = '0;
          rsp_d.status     = ST_OK;
          state_d          = S_IDLE;
        end else begin
          // rdata holds entry cur-1; next read runs one below the write
          wdata = rdata;
          raddr = cur_q - AW'(2);
          cur_d = cur_q - AW'(1);
        end
      end

      S_SHDN: begin
        // count already holds the new value; last move lands at count-1
        we    = 1'b1;
        wdata = rdata;
        if (XW'(cur_q) + XW'(1) == cnt_x) begin
          valid_d          = 1'b1;
          rsp_d.read_value = '0;
          rsp_d.status     = ST_OK;
          state_d          = S_IDLE;
        end else begin
          raddr = cur_q + AW'(2);
          cur_d = cur_q + AW'(1);
        end
      end

      S_RDOUT: begin
        valid_d          = 1'b1;
        rsp_d.read_value = rdata;
        rsp_d.status     = ST_OK;
        state_d          = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.fill_count = count_d;
    rsp_d.empty_flag = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pos_q <= pos_d;
    val_q <= val_d;
    rsp_q <= rsp_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // an accepted request either starts a sequence or answers next cycle
  `SIAL_ASSERT(a_req_answered, start_i && !busy_o |=> busy_o || valid_o, "request lost")
  // the count never passes capacity
  `SIAL_ASSERT_ALWAYS(a_count_cap, !rst_ni || count_q <= CapC, "count above capacity")
  // a full status is only reported on a full list
  `SIAL_ASSERT(a_full_status, valid_o && rsp_o.status == ST_FULL |-> count_q == CapC,
               "full status with room left")
  // shift-up only runs with a free slot at the top
  `SIAL_ASSERT(a_shup_room, state_q == S_SHUP |-> count_q < CapC, "shift up on full list")

endmodule

// ===== dv/shift_insert_array_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_insert_array_list_checker
// Watches the request and response channels of the list core and keeps its
// own copy of the list. Each accepted request updates that copy and queues
// the response it should give. Each response strobe is compared field by
// field with the oldest queued response.
// ----------------------------------------------------------------------------
module shift_insert_array_list_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  sial_pkg::sial_req_t req_i,
  input  logic                valid_i,
  input  sial_pkg::sial_rsp_t rsp_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import sial_pkg::*;

  localparam int PRINT_CAP = 40;

  logic signed [31:0] list_words [CAPACITY];
  int                 list_len;
  sial_rsp_t          expected_rsps [$];
  sial_rsp_t          oldest_rsp;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count_o < PRINT_CAP) begin
      $display("%0t: checker: %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    fail_count_o++;
  endtask

  // Applies one request to the list copy and returns the response it gives.
  function automatic sial_rsp_t apply_request(input sial_req_t r);
    sial_rsp_t rsp;
    int        pos;
    int        i;
    rsp = '0;
    pos = int'(r.position);
    case (r.kind)
      KIND_APPEND: begin
        if (list_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          list_words[list_len] = r.item_value;
          list_len++;
        end
      end
      KIND_PREPEND: begin
        if (list_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          for (i = list_len; i > 0; i--) list_words[i] = list_words[i - 1];
          list_words[0] = r.item_value;
          list_len++;
        end
      end
      KIND_INSERT: begin
        if (pos >= CAPACITY) begin
          rsp.status = ST_INDEX;
        end else if (pos >= list_len) begin
          // past the end: zero the gap, count becomes index + 1
          for (i = list_len; i < pos; i++) list_words[i] = '0;
          list_words[pos] = r.item_value;
          list_len        = pos + 1;
        end else if (list_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i - 1];
          list_words[pos] = r.item_value;
          list_len++;
        end
      end
      KIND_POP: begin
        if (list_len == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          list_len--;
          rsp.read_value = list_words[list_len];
        end
      end
      KIND_DELETE: begin
        if (pos >= list_len) begin
          rsp.status = ST_INDEX;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      KIND_READ: begin
        if (pos >= list_len) rsp.status = ST_INDEX;
        else rsp.read_value = list_words[pos];
      end
      default: ;  // unused kinds leave the list alone
    endcase
    rsp.fill_count = 5'(list_len);
    rsp.empty_flag = (list_len == 0);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      foreach (list_words[i]) list_words[i] = '0;
      expected_rsps.delete();
      pending_o = 0;
    end else begin
      // response first: a new request may be taken on the strobe cycle
      if (valid_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with nothing outstanding", rsp_i.read_value, '0);
        end else begin
          oldest_rsp = expected_rsps.pop_front();
          if (rsp_i.read_value !== oldest_rsp.read_value)
            report_mismatch("read_value", rsp_i.read_value, oldest_rsp.read_value);
          if (rsp_i.fill_count !== oldest_rsp.fill_count)
            report_mismatch("fill_count", rsp_i.fill_count, oldest_rsp.fill_count);
          if (rsp_i.empty_flag !== oldest_rsp.empty_flag)
            report_mismatch("empty_flag", rsp_i.empty_flag, oldest_rsp.empty_flag);
          if (rsp_i.status !== oldest_rsp.status)
            report_mismatch("status", rsp_i.status, oldest_rsp.status);
        end
      end
      if (start_i && !busy_i) expected_rsps = {expected_rsps, apply_request(req_i)};
      pending_o = expected_rsps.size();
    end
  end

endmodule

// ===== dv/tb_shift_insert_array_list_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shift_insert_array_list_core
// Drives append, prepend, insert, pop, delete and read requests into the list
// core: a directed sweep of the corner cases, then random traffic that swings
// the list between empty and full. A checker beside the core predicts and
// compares every response; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_shift_insert_array_list_core;
  import sial_pkg::*;

  localparam int  CAPACITY     = 16;
  localparam int  RANDOM_ITEMS = 550;
  // margin over the longest shift or gap fill
  localparam int  DRAIN_CYCLES = CAPACITY + 8;
  // slowest run: ~575 transfers, each a longest busy span plus its idle gap, taken ~15x over
  localparam time RUN_LIMIT    = 2_000_000;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  sial_req_t req_i;
  logic      busy_o;
  logic      valid_o;
  sial_rsp_t rsp_o;

  int fail_count;
  int pending;

  // Stimulus shaping state: last count reported by the core, whether the
  // traffic currently leans toward filling the list, and the transfers left
  // in the current burst before the next idle gap.
  int list_fill;
  bit grow;
  int burst_left;

  shift_insert_array_list_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  shift_insert_array_list_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .valid_i     (valid_o),
    .rsp_i       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hard stop in case the core hangs on busy or never answers.
  initial begin
    #(RUN_LIMIT);
    $display("[shift_insert_array_list_core] ERROR");
    $finish;
  end

  // Track the count the core reports; only used to steer the random mix.
  always @(posedge clk_i) begin
    if (valid_o) list_fill <= int'(rsp_o.fill_count);
  end

  function automatic sial_req_t mk_req(input logic [2:0] kind, input int pos,
                                       input logic [31:0] value);
    sial_req_t r;
    r.kind       = kind;
    r.position   = 4'(pos);
    r.item_value = value;
    return r;
  endfunction

  // Random request steered by the current fill level. While growing, adds
  // dominate so the list reaches full; while shrinking, pops and deletes
  // dominate so it drains to empty. Positions mostly land inside the list,
  // sometimes anywhere, so index errors and gap fills keep showing up.
  function automatic sial_req_t pick_request(input int fill, input bit up);
    sial_req_t r;
    int        roll;
    int        pos;
    logic [31:0] value;
    roll = $urandom_range(0, 99);
    if (up) begin
      if      (roll < 22) r.kind = KIND_APPEND;
      else if (roll < 38) r.kind = KIND_PREPEND;
      else if (roll < 62) r.kind = KIND_INSERT;
      else if (roll < 70) r.kind = KIND_POP;
      else if (roll < 78) r.kind = KIND_DELETE;
      else if (roll < 96) r.kind = KIND_READ;
      else                r.kind = 3'($urandom_range(6, 7));  // unused kinds
    end else begin
      if      (roll < 8)  r.kind = KIND_APPEND;
      else if (roll < 14) r.kind = KIND_PREPEND;
      else if (roll < 22) r.kind = KIND_INSERT;
      else if (roll < 47) r.kind = KIND_POP;
      else if (roll < 72) r.kind = KIND_DELETE;
      else if (roll < 96) r.kind = KIND_READ;
      else                r.kind = 3'($urandom_range(6, 7));
    end
    if (fill > 0 && $urandom_range(0, 9) < 7) begin
      // inserts may also land exactly at the end
      pos = (r.kind == KIND_INSERT) ? $urandom_range(0, fill) : $urandom_range(0, fill - 1);
    end else begin
      pos = $urandom_range(0, CAPACITY - 1);
    end
    case ($urandom_range(0, 11))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7FFF_FFFF;
      2:       value = 32'hFFFF_FFFF;
      3:       value = 32'h0000_0000;
      default: value = $urandom;
    endcase
    return mk_req(r.kind, pos, value);
  endfunction

  // One request transfer. Called on a rising edge; returns on the edge that
  // took the request, or after the random idle gap that ends a burst, while
  // start_i is low and req_i carries junk the core must ignore. Within a
  // burst start_i stays high, so it gets exactly one assignment per step.
  task automatic issue(input sial_req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      req_i   <= pick_request(list_fill, grow);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // mostly short bursts, now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_i      = '0;
    list_fill  = 0;
    grow       = 1'b1;
    burst_left = $urandom_range(0, 8);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: corner cases in a fixed order ----
    // empty list: bad read, pop underflow, bad delete, ignored kind
    issue(mk_req(KIND_READ,   0, 32'h0));
    issue(mk_req(KIND_POP,    0, 32'h0));
    issue(mk_req(KIND_DELETE, 0, 32'h0));
    issue(mk_req(3'd6,        9, 32'hDEAD_BEEF));
    // insert past the end of an empty list: zero fill below index 3
    issue(mk_req(KIND_INSERT,  3, 32'h7FFF_FFFF));
    issue(mk_req(KIND_READ,    1, 32'h0));
    issue(mk_req(KIND_PREPEND, 0, 32'h8000_0000));
    issue(mk_req(KIND_INSERT,  2, 32'hFFFF_FFFF));  // shift up from the middle
    issue(mk_req(KIND_APPEND,  0, 32'h1234_5678));
    issue(mk_req(KIND_READ,    0, 32'h0));
    issue(mk_req(KIND_READ,    6, 32'h0));           // last element
    issue(mk_req(KIND_READ,    7, 32'h0));           // one past the end
    issue(mk_req(KIND_DELETE,  0, 32'h0));           // shift down from the head
    issue(mk_req(KIND_DELETE,  5, 32'h0));           // delete of the last element
    issue(mk_req(KIND_POP,     0, 32'h0));
    // zero fill up to the top slot: list becomes full
    issue(mk_req(KIND_INSERT, 15, 32'h5A5A_5A5A));
    issue(mk_req(KIND_APPEND,  0, 32'h0000_0001));  // full
    issue(mk_req(KIND_PREPEND, 0, 32'h0000_0002));  // full
    issue(mk_req(KIND_INSERT,  4, 32'h0000_0003));  // full, inside the list
    issue(mk_req(KIND_INSERT, 15, 32'h0000_0004));  // full, top slot
    issue(mk_req(KIND_READ,   15, 32'h0));
    issue(mk_req(KIND_DELETE, 15, 32'h0));
    issue(mk_req(3'd7,         0, 32'hFFFF_FFFF));
    issue(mk_req(KIND_DELETE,  9, 32'h0));
    issue(mk_req(KIND_POP,     0, 32'h0));

    // ---- random: swing between empty and full ----
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (list_fill >= CAPACITY - 1) grow = 1'b0;
      else if (list_fill <= 1)       grow = 1'b1;
      else if ($urandom_range(0, 49) == 0) grow = ~grow;
      issue(pick_request(list_fill, grow));
    end
    start_i <= 1'b0;

    // wait for the last response, then let any trailing work settle
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("[shift_insert_array_list_core] OK");
    end else begin
      $display("[shift_insert_array_list_core] ERROR");
    end
    $finish;
  end

endmodule
